// ===== rtl/olc_pkg.sv =====
`default_nettype none

package olc_pkg;

    // Table sizes and field widths
    localparam int GENES          = 4096;
    localparam int TAXA           = 64;
    localparam int KEY_BITS       = 32;
    localparam int GENE_BITS      = 12;
    localparam int TAXON_BITS     = 6;
    localparam int GENE_IDX_BITS  = $clog2(GENES);
    localparam int TAXON_IDX_BITS = $clog2(TAXA);

    // Query epoch tags for the subject-seen store; tag zero means never seen
    localparam int EPOCH_BITS = 8;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = {EPOCH_BITS{1'b1}};
    localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = '0;

    // Result queue between classifier and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // "No link yet" key (largest float maps to all ones)
    localparam logic [KEY_BITS-1:0] KEY_ONES = {KEY_BITS{1'b1}};

    typedef enum logic [1:0] {
        CAT_TOP_INTRA   = 2'd0,
        CAT_BEST_INTER  = 2'd1,
        CAT_OTHER_INTER = 2'd2
    } cat_t;

    typedef struct packed {
        logic                  new_query;
        logic [GENE_BITS-1:0]  query_gene;
        logic [TAXON_BITS-1:0] query_taxon;
        logic [GENE_BITS-1:0]  subject_gene;
        logic [TAXON_BITS-1:0] subject_taxon;
        logic [KEY_BITS-1:0]   e_key;
        logic                  link_valid;
    } link_t;

    typedef struct packed {
        cat_t                 category;
        logic [GENE_BITS-1:0] low_gene;
        logic [GENE_BITS-1:0] high_gene;
        logic [KEY_BITS-1:0]  link_e_key;
    } pair_t;

    typedef struct packed {
        cat_t                 category;
        logic [GENE_BITS-1:0] query_gene;
        logic [GENE_BITS-1:0] subject_gene;
        logic [KEY_BITS-1:0]  e_key;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

endpackage

`default_nettype wire

// ===== rtl/olc_in_if.sv =====
`default_nettype none

interface olc_in_if import olc_pkg::*;;
    logic  valid;
    logic  ready;
    link_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/olc_out_if.sv =====
`default_nettype none

interface olc_out_if import olc_pkg::*;;
    logic  valid;
    logic  ready;
    pair_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/olc_ram.sv =====
`default_nettype none

module olc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/olc_front.sv =====
`default_nettype none

module olc_front import olc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    olc_in_if.sink                      links,
    input  wire logic [QCOUNT_BITS-1:0] queue_count,
    output push_t                       push
);

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_SWEEP = 2'b10
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [GENE_IDX_BITS-1:0] sweep_addr_reg, sweep_addr_next;
    logic [EPOCH_BITS-1:0]    epoch_reg, epoch_next;

    logic                  s1_valid_reg;
    link_t                 s1_item_reg;
    logic [EPOCH_BITS-1:0] s1_epoch_reg;

    logic [GENE_BITS-1:0]  cur_query_reg, cur_query_next;
    logic [TAXON_BITS-1:0] cur_taxon_reg, cur_taxon_next;
    logic [KEY_BITS-1:0]   inter_reg, inter_next;
    logic [TAXA-1:0]       tb_valid_reg, tb_valid_next;

    logic                      seen_fwd_valid_reg;
    logic [GENE_IDX_BITS-1:0]  seen_fwd_addr_reg;
    logic [EPOCH_BITS-1:0]     seen_fwd_tag_reg;
    logic                      tb_fwd_valid_reg;
    logic [TAXON_IDX_BITS-1:0] tb_fwd_addr_reg;
    logic [KEY_BITS-1:0]       tb_fwd_data_reg;

    logic                  accept;
    logic                  wrap_block;
    logic                  credit_ok;
    logic [EPOCH_BITS-1:0] seen_rdata;
    logic [KEY_BITS-1:0]   tb_rdata;

    logic                      seen_ram_we;
    logic [GENE_IDX_BITS-1:0]  seen_ram_waddr;
    logic [EPOCH_BITS-1:0]     seen_ram_wdata;

    logic                      nq;
    logic [GENE_IDX_BITS-1:0]  s1_gene_idx;
    logic [TAXON_IDX_BITS-1:0] s1_taxon_idx;
    logic [GENE_BITS-1:0]      eff_query;
    logic [TAXON_BITS-1:0]     eff_taxon;
    logic [KEY_BITS-1:0]       eff_inter;
    logic [EPOCH_BITS-1:0]     seen_tag;
    logic                      seen;
    logic [KEY_BITS-1:0]       tb_eff;
    logic                      same_taxon;
    logic                      seen_we;
    logic                      tb_we;
    logic                      emit;
    cat_t                      cat;

    // Input handshake: hold off during a sweep, when the queue could overflow,
    // or when a new query would reuse a live epoch tag
    assign credit_ok = ((QCOUNT_BITS+1)'(queue_count) + (QCOUNT_BITS+1)'(s1_valid_reg))
                       < (QCOUNT_BITS+1)'(QUEUE_DEPTH);
    assign wrap_block = links.valid && links.payload.new_query && (epoch_reg == EPOCH_MAX);
    assign links.ready = (state_reg == ST_RUN) && credit_ok && !wrap_block;
    assign accept = links.valid && links.ready;

    olc_ram #(
        .WIDTH (EPOCH_BITS),
        .DEPTH (GENES)
    ) u_seen_ram (
        .clk   (clk),
        .we    (seen_ram_we),
        .waddr (seen_ram_waddr),
        .wdata (seen_ram_wdata),
        .raddr (links.payload.subject_gene[GENE_IDX_BITS-1:0]),
        .rdata (seen_rdata)
    );

    olc_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TAXA)
    ) u_taxon_ram (
        .clk   (clk),
        .we    (tb_we),
        .waddr (s1_taxon_idx),
        .wdata (s1_item_reg.e_key),
        .raddr (links.payload.subject_taxon[TAXON_IDX_BITS-1:0]),
        .rdata (tb_rdata)
    );

    // Classify the item in the lookup stage
    always_comb
    begin
        nq           = s1_item_reg.new_query;
        s1_gene_idx  = s1_item_reg.subject_gene[GENE_IDX_BITS-1:0];
        s1_taxon_idx = s1_item_reg.subject_taxon[TAXON_IDX_BITS-1:0];
        eff_query    = nq ? s1_item_reg.query_gene : cur_query_reg;
        eff_taxon    = nq ? s1_item_reg.query_taxon : cur_taxon_reg;
        eff_inter    = nq ? KEY_ONES : inter_reg;

        seen_tag = (seen_fwd_valid_reg && (seen_fwd_addr_reg == s1_gene_idx))
                   ? seen_fwd_tag_reg : seen_rdata;
        seen     = (seen_tag == s1_epoch_reg);

        if (nq)
        begin
            tb_eff = KEY_ONES;
        end
        else if (tb_fwd_valid_reg && (tb_fwd_addr_reg == s1_taxon_idx))
        begin
            tb_eff = tb_fwd_data_reg;
        end
        else
        begin
            tb_eff = tb_valid_reg[s1_taxon_idx] ? tb_rdata : KEY_ONES;
        end

        same_taxon = (eff_taxon == s1_item_reg.subject_taxon);
        seen_we    = 1'b0;
        tb_we      = 1'b0;
        emit       = 1'b0;
        cat        = CAT_TOP_INTRA;
        inter_next = s1_valid_reg ? eff_inter : inter_reg;

        if (s1_valid_reg)
        begin
            if (s1_item_reg.link_valid)
            begin
                if (!seen)
                begin
                    seen_we = 1'b1;
                    if (same_taxon)
                    begin
                        emit = (s1_item_reg.e_key <= eff_inter);
                        cat  = CAT_TOP_INTRA;
                    end
                    else if (tb_eff < s1_item_reg.e_key)
                    begin
                        emit = 1'b1;
                        cat  = CAT_OTHER_INTER;
                    end
                    else
                    begin
                        emit  = 1'b1;
                        cat   = CAT_BEST_INTER;
                        tb_we = 1'b1;
                        if (s1_item_reg.e_key < eff_inter)
                        begin
                            inter_next = s1_item_reg.e_key;
                        end
                    end
                end
            end
            else if (!same_taxon && (s1_item_reg.e_key < tb_eff))
            begin
                tb_we = 1'b1;
            end
        end

        cur_query_next = s1_valid_reg ? eff_query : cur_query_reg;
        cur_taxon_next = s1_valid_reg ? eff_taxon : cur_taxon_reg;

        tb_valid_next = (s1_valid_reg && nq) ? '0 : tb_valid_reg;
        if (tb_we)
        begin
            tb_valid_next[s1_taxon_idx] = 1'b1;
        end
    end

    assign push.valid              = emit;
    assign push.entry.category     = cat;
    assign push.entry.query_gene   = eff_query;
    assign push.entry.subject_gene = s1_item_reg.subject_gene;
    assign push.entry.e_key        = s1_item_reg.e_key;

    // Seen store write port: sweep or mark
    always_comb
    begin
        if (state_reg == ST_SWEEP)
        begin
            seen_ram_we    = 1'b1;
            seen_ram_waddr = sweep_addr_reg;
            seen_ram_wdata = EPOCH_NONE;
        end
        else
        begin
            seen_ram_we    = seen_we;
            seen_ram_waddr = s1_gene_idx;
            seen_ram_wdata = s1_epoch_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        epoch_next      = epoch_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (accept && links.payload.new_query)
                begin
                    epoch_next = epoch_reg + EPOCH_BITS'(1);
                end
                else if (wrap_block)
                begin
                    state_next      = ST_SWEEP;
                    sweep_addr_next = '0;
                end
            end
            ST_SWEEP:
            begin
                sweep_addr_next = sweep_addr_reg + GENE_IDX_BITS'(1);
                if (sweep_addr_reg == {GENE_IDX_BITS{1'b1}})
                begin
                    state_next = ST_RUN;
                    epoch_next = EPOCH_FIRST;
                end
            end
            default:
            begin
                state_next      = ST_SWEEP;
                sweep_addr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_SWEEP;
            sweep_addr_reg     <= '0;
            epoch_reg          <= EPOCH_FIRST;
            s1_valid_reg       <= 1'b0;
            cur_query_reg      <= '0;
            cur_taxon_reg      <= '0;
            inter_reg          <= KEY_ONES;
            tb_valid_reg       <= '0;
            seen_fwd_valid_reg <= 1'b0;
            tb_fwd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            sweep_addr_reg     <= sweep_addr_next;
            epoch_reg          <= epoch_next;
            s1_valid_reg       <= accept;
            cur_query_reg      <= cur_query_next;
            cur_taxon_reg      <= cur_taxon_next;
            inter_reg          <= inter_next;
            tb_valid_reg       <= tb_valid_next;
            seen_fwd_valid_reg <= seen_we;
            tb_fwd_valid_reg   <= tb_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= links.payload;
            s1_epoch_reg <= links.payload.new_query ? (epoch_reg + EPOCH_BITS'(1)) : epoch_reg;
        end
        seen_fwd_addr_reg <= s1_gene_idx;
        seen_fwd_tag_reg  <= s1_epoch_reg;
        tb_fwd_addr_reg   <= s1_taxon_idx;
        tb_fwd_data_reg   <= s1_item_reg.e_key;
    end

    a_sweep_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> !s1_valid_reg)
        else $error("lookup stage busy during seen-store sweep");

    a_no_epoch_reuse: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && links.payload.new_query) |-> (epoch_reg != EPOCH_MAX))
        else $error("new query accepted at last epoch tag");

    a_emit_only_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (s1_valid_reg && s1_item_reg.link_valid && seen_we))
        else $error("result pushed for a repeated or invalid link");

endmodule

`default_nettype wire

// ===== rtl/olc_queue.sv =====
`default_nettype none

module olc_queue import olc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire push_t                  push,
    input  wire logic                   pop,
    output entry_t                      head,
    output logic      [QCOUNT_BITS-1:0] count
);

    entry_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_BITS-1:0] count_reg, count_next;

    function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
        ptr_inc = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
    endfunction

    assign head  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

    always_comb
    begin
        wr_ptr_next = push.valid ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCOUNT_BITS'(push.valid) - QCOUNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (count_reg < QCOUNT_BITS'(QUEUE_DEPTH)))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("result queue underflow");

endmodule

`default_nettype wire

// ===== rtl/olc_back.sv =====
`default_nettype none

module olc_back import olc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire entry_t                 head,
    input  wire logic [QCOUNT_BITS-1:0] queue_count,
    output logic                        pop,
    olc_out_if.source                   pairs
);

    logic  out_valid_reg, out_valid_next;
    pair_t out_reg, out_next;

    // Advance the queue head into the output register when it is free
    assign pop = (queue_count != '0) && (!out_valid_reg || pairs.ready);

    always_comb
    begin
        out_valid_next = pop ? 1'b1 : (out_valid_reg && !pairs.ready);
        out_next       = out_reg;
        if (pop)
        begin
            out_next.category   = head.category;
            out_next.link_e_key = head.e_key;
            if (head.query_gene < head.subject_gene)
            begin
                out_next.low_gene  = head.query_gene;
                out_next.high_gene = head.subject_gene;
            end
            else
            begin
                out_next.low_gene  = head.subject_gene;
                out_next.high_gene = head.query_gene;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign pairs.valid   = out_valid_reg;
    assign pairs.payload = out_reg;

    a_pair_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        pairs.valid |-> (pairs.payload.low_gene <= pairs.payload.high_gene))
        else $error("gene pair not ordered");

endmodule

`default_nettype wire

// ===== rtl/ortholog_link_classifier_top.sv =====
// Channel   Dir  Handshake     Payload
// links     in   valid/ready   link_t: new_query, query/subject gene+taxon, e_key, link_valid
// pairs     out  valid/ready   pair_t: category, low_gene, high_gene, link_e_key
//
// One link per cycle without stalls; a result passes the lookup, queue and output registers.
// Reset starts a sweep of the subject-seen store, clearing it with links.ready low.
// Epoch tags run out after 254 new queries; the next new query waits for a seen-store sweep.
// Besides sweeps, the classifier stalls only on the 4-entry result queue, counted by credit.
`default_nettype none

module ortholog_link_classifier_top import olc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    olc_in_if.sink    links,
    olc_out_if.source pairs
);

    // Classifier to queue: one result transaction per cycle at most
    push_t                  push;
    // Queue occupancy serves both as credit for the front and as
    // not-empty for the back
    logic [QCOUNT_BITS-1:0] queue_count;
    entry_t                 head;
    logic                   pop;

    // Front: epoch-tagged seen store, per-taxon best keys, forwarding of
    // the previous write, classification of one link per cycle unless stalled
    olc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .links       (links),
        .queue_count (queue_count),
        .push        (push)
    );

    // Short queue decoupling classification from output backpressure
    olc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .count (queue_count)
    );

    // Back: order the gene pair and hold the result in the output register
    olc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .queue_count (queue_count),
        .pop         (pop),
        .pairs       (pairs)
    );

endmodule

`default_nettype wire
